// ----- hdl/button_click_classifier_core_assert.svh -----
// Assertion macros for the button click classifier core.
// Included by the top level; no other dependencies.
`ifndef BUTTON_CLICK_CLASSIFIER_CORE_ASSERT_SVH
`define BUTTON_CLICK_CLASSIFIER_CORE_ASSERT_SVH

`ifndef ASSERT_OFF

// same-cycle implication, checked outside reset
`define BCC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("bcc assertion failed");

// next-cycle implication, checked outside reset
`define BCC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("bcc assertion failed");

`else

`define BCC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define BCC_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- hdl/bcc_pkg.sv -----
// Shared types and constants for the button click classifier.
// No dependencies; imported by every module of the block.
package bcc_pkg;

    localparam int TIMER_BITS_DEF = 16;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int TICKS_W    = 16;
    localparam int TAG_W      = 8;
    localparam int KIND_W     = 2;
    localparam int S_TDATA_W  = 8;

    localparam logic [TICKS_W-1:0] LONG_TICKS_RST   = 16'd1000;
    localparam logic [TICKS_W-1:0] DOUBLE_TICKS_RST = 16'd300;
    localparam logic [TAG_W-1:0]   BUTTON_TAG_RST   = 8'd0;

    // register map of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LONG_TICKS   = 2'd0,
        CFG_DOUBLE_TICKS = 2'd1,
        CFG_BUTTON_NUM   = 2'd2
    } t_cfg_reg;

    typedef enum logic [KIND_W-1:0] {
        EV_CLICK      = 2'd0,
        EV_DOUBLE     = 2'd1,
        EV_LONG       = 2'd2,
        EV_CLICK_LONG = 2'd3
    } t_event_kind;

    // press tracking flags
    typedef struct packed {
        logic       held;
        logic [1:0] presses;
        logic       long_seen;
        logic       wait_armed;
    } t_flags;

endpackage

// ----- hdl/button_click_classifier_core.sv -----
// Top level of the button click classifier: config registers, state, output stage.
// Uses bcc_pkg, bcc_update, bcc_out_skid and the assertion macro header.
//
//  channel   dir  handshake                    payload
//  s (tick)  in   i_s_tvalid / o_s_tready      i_s_tdata[0] = level
//  m (event) out  o_m_tvalid / i_m_tready      o_m_tdata = button_tag, o_m_tuser = event_kind
//  cfg       in   i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//
// One tick is taken per cycle while the output stage has room; its event, if any, is pushed into that stage.
// The rate is set by the two-entry output stage: ticks stall only when both entries hold
// events the sink has not taken.
// Reset (synchronous, active low) clears the press state, counters and output stage and
// loads the register defaults. Config writes are always taken.
`include "button_click_classifier_core_assert.svh"

module button_click_classifier_core
    import bcc_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [S_TDATA_W-1:0]  i_s_tdata,    // [0] level, [7:1] zero
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [TAG_W-1:0]      o_m_tdata,    // [7:0] button_tag
    output logic [KIND_W-1:0]     o_m_tuser,    // [1:0] event_kind
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [TICKS_W-1:0]    r_long_ticks;
    logic [TICKS_W-1:0]    r_double_ticks;
    logic [TAG_W-1:0]      r_button_tag;
    t_flags                r_flags;
    t_flags                n_flags;
    logic [TIMER_BITS-1:0] r_since_press;
    logic [TIMER_BITS-1:0] r_since_release;
    logic [TIMER_BITS-1:0] n_since_press;
    logic [TIMER_BITS-1:0] n_since_release;
    logic                  w_emit;
    t_event_kind           w_kind;
    logic                  w_accept;
    logic                  w_out_ready;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = w_out_ready;
    assign w_accept    = i_s_tvalid && w_out_ready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_ticks   <= LONG_TICKS_RST;
            r_double_ticks <= DOUBLE_TICKS_RST;
            r_button_tag   <= BUTTON_TAG_RST;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_LONG_TICKS:   r_long_ticks   <= i_cfg_data;
                CFG_DOUBLE_TICKS: r_double_ticks <= i_cfg_data;
                CFG_BUTTON_NUM:   r_button_tag   <= i_cfg_data[TAG_W-1:0];
                default: ;
            endcase
        end
    end

    // per-tick update
    bcc_update #(
        .TIMER_BITS(TIMER_BITS)
    ) u_update (
        .i_level        (i_s_tdata[0]),
        .i_flags        (r_flags),
        .i_since_press  (r_since_press),
        .i_since_release(r_since_release),
        .i_long_ticks   (r_long_ticks),
        .i_double_ticks (r_double_ticks),
        .o_flags        (n_flags),
        .o_since_press  (n_since_press),
        .o_since_release(n_since_release),
        .o_emit         (w_emit),
        .o_kind         (w_kind)
    );

    // press state and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags         <= '0;
            r_since_press   <= '0;
            r_since_release <= '0;
        end else if (w_accept) begin
            r_flags         <= n_flags;
            r_since_press   <= n_since_press;
            r_since_release <= n_since_release;
        end
    end

    // result stage
    bcc_out_skid #(
        .DATA_W(KIND_W + TAG_W)
    ) u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_accept && w_emit),
        .i_data     ({w_kind, r_button_tag}),
        .o_ready    (w_out_ready),
        .o_valid    (o_m_tvalid),
        .i_pop_ready(i_m_tready),
        .o_data     ({o_m_tuser, o_m_tdata})
    );

    // checks
    `BCC_ASSERT_IMP(a_presses_bounded, i_clk, i_rst_n, 1'b1, r_flags.presses != 2'd3)
    `BCC_ASSERT_IMP(a_stall_only_when_full, i_clk, i_rst_n, !w_out_ready, o_m_tvalid)
    `BCC_ASSERT_NEXT(a_event_shows, i_clk, i_rst_n, w_accept && w_emit, o_m_tvalid)
    `BCC_ASSERT_IMP(a_held_no_wait_loss, i_clk, i_rst_n, r_flags.wait_armed, r_flags.presses != 2'd0)

endmodule

// ----- hdl/bcc_update.sv -----
// Next-state and event logic of the click classifier for one tick.
// Purely combinational; uses bcc_pkg.
module bcc_update
    import bcc_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEF
) (
    input  logic                  i_level,
    input  t_flags                i_flags,
    input  logic [TIMER_BITS-1:0] i_since_press,
    input  logic [TIMER_BITS-1:0] i_since_release,
    input  logic [TICKS_W-1:0]    i_long_ticks,
    input  logic [TICKS_W-1:0]    i_double_ticks,
    output t_flags                o_flags,
    output logic [TIMER_BITS-1:0] o_since_press,
    output logic [TIMER_BITS-1:0] o_since_release,
    output logic                  o_emit,
    output t_event_kind           o_kind
);

    localparam int CMP_W = (TIMER_BITS > TICKS_W) ? TIMER_BITS : TICKS_W;

    logic [TIMER_BITS-1:0] w_sp_inc;
    logic [TIMER_BITS-1:0] w_sr_inc;
    logic [CMP_W-1:0]      w_sp_cmp;
    logic [CMP_W-1:0]      w_sr_cmp;
    logic [CMP_W-1:0]      w_long_cmp;
    logic [CMP_W-1:0]      w_double_cmp;
    t_flags                w_fl;
    logic                  w_single_due;

    // saturating tick counters
    assign w_sp_inc = (&i_since_press)   ? i_since_press   : i_since_press + 1'b1;
    assign w_sr_inc = (&i_since_release) ? i_since_release : i_since_release + 1'b1;

    assign w_sp_cmp     = CMP_W'(w_sp_inc);
    assign w_long_cmp   = CMP_W'(i_long_ticks);
    assign w_double_cmp = CMP_W'(i_double_ticks);

    // press and release edges
    always_comb begin
        w_fl            = i_flags;
        o_since_press   = w_sp_inc;
        o_since_release = w_sr_inc;
        if (i_level && !i_flags.held) begin
            w_fl.held     = 1'b1;
            o_since_press = '0;
            if (i_flags.presses != 2'd3) begin
                w_fl.presses = i_flags.presses + 2'd1;
            end
        end else if (!i_level && i_flags.held) begin
            w_fl.held       = 1'b0;
            o_since_release = '0;
            if (w_sp_cmp >= w_long_cmp) begin
                w_fl.long_seen = 1'b1;
            end
            if (i_flags.presses == 2'd1) begin
                w_fl.wait_armed = 1'b1;
            end
        end
    end

    assign w_sr_cmp = CMP_W'(o_since_release);

    // single press times out, or second release reports at once
    assign w_single_due = (w_fl.presses == 2'd1) && w_fl.wait_armed
                          && (w_sr_cmp > w_double_cmp);
    assign o_emit = !w_fl.held && (w_single_due || (w_fl.presses > 2'd1));

    // event classification
    always_comb begin
        priority if (w_fl.long_seen && (w_fl.presses == 2'd1)) begin
            o_kind = EV_LONG;
        end else if (w_fl.long_seen && (w_fl.presses > 2'd1)) begin
            o_kind = EV_CLICK_LONG;
        end else if (w_fl.presses > 2'd1) begin
            o_kind = EV_DOUBLE;
        end else if (w_fl.long_seen) begin
            o_kind = EV_LONG;
        end else begin
            o_kind = EV_CLICK;
        end
    end

    // clear press state once reported
    always_comb begin
        o_flags = w_fl;
        if (o_emit) begin
            o_flags.presses    = 2'd0;
            o_flags.long_seen  = 1'b0;
            o_flags.wait_armed = 1'b0;
        end
    end

endmodule

// ----- hdl/bcc_out_skid.sv -----
// Two-entry output register with skid stage for the result stream.
// Uses bcc_pkg for consistency of the project; no submodules.
module bcc_out_skid
    import bcc_pkg::*;
#(
    parameter int DATA_W = KIND_W + TAG_W
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_ready,
    output logic              o_valid,
    input  logic              i_pop_ready,
    output logic [DATA_W-1:0] o_data
);

    logic              r_main_valid;
    logic              r_skid_valid;
    logic [DATA_W-1:0] r_main;
    logic [DATA_W-1:0] r_skid;
    logic              w_pop;

    assign w_pop   = r_main_valid && i_pop_ready;
    assign o_valid = r_main_valid;
    assign o_data  = r_main;
    assign o_ready = !r_skid_valid;

    // valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_pop && r_skid_valid) begin
            r_skid_valid <= 1'b0;
        end else if (w_pop) begin
            r_main_valid <= i_push;
        end else if (i_push) begin
            if (r_main_valid) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_main_valid <= 1'b1;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_pop && r_skid_valid) begin
            r_main <= r_skid;
        end else if (i_push && (w_pop || !r_main_valid)) begin
            r_main <= i_data;
        end else if (i_push) begin
            r_skid <= i_data;
        end
    end

endmodule

// ----- dv/button_click_classifier_core_test.sv -----
// Testbench for button_click_classifier_core: drives level ticks and register writes,
// predicts every click event and checks it. Depends on bcc_pkg and the core RTL only.
`timescale 1ns / 100ps

module button_click_classifier_core_test;
    import bcc_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 5_000_000;
    localparam int MAX_RUN = 60;             // far below the maximum thresholds
    localparam int GESTURE_TICKS = 150;      // ticks per random phase
    localparam int SETTLE_CYCLES = 8;        // event latency plus the two-entry output stage
    localparam int LONG_HOLD_CYCLES = 400;

    typedef struct {
        t_event_kind        kind;
        logic [TAG_W-1:0]   tag;
    } click_event_t;

    typedef enum {SINK_READY, SINK_MOSTLY, SINK_SPARSE, SINK_PATTERN} sink_mode_t;

    // press tracking model and queue of predicted events
    class click_scoreboard;
        logic [TICKS_W-1:0] long_ticks;
        logic [TICKS_W-1:0] double_ticks;
        logic [TAG_W-1:0]   button_tag;
        bit                 held;
        bit                 long_seen;
        bit                 wait_armed;
        logic [1:0]         presses;
        logic [TICKS_W-1:0] since_press;
        logic [TICKS_W-1:0] since_release;
        click_event_t       expected_events[$];
        int                 errors;
        int                 ticks;
        int                 kind_count[4];

        function new();
            long_ticks = LONG_TICKS_RST;
            double_ticks = DOUBLE_TICKS_RST;
            button_tag = BUTTON_TAG_RST;
            held = 1'b0;
            long_seen = 1'b0;
            wait_armed = 1'b0;
            presses = '0;
            since_press = '0;
            since_release = '0;
            errors = 0;
            ticks = 0;
            foreach (kind_count[k]) kind_count[k] = 0;
        endfunction

        function void write_reg(t_cfg_reg r, logic [CFG_DATA_W-1:0] v);
            case (r)
                CFG_LONG_TICKS: long_ticks = v;
                CFG_DOUBLE_TICKS: double_ticks = v;
                CFG_BUTTON_NUM: button_tag = v[TAG_W-1:0];
                default: ;
            endcase
        endfunction

        function t_event_kind classify();
            if (long_seen && presses == 2'd1) return EV_LONG;
            if (long_seen && presses > 2'd1) return EV_CLICK_LONG;
            if (presses > 2'd1) return EV_DOUBLE;
            if (long_seen) return EV_LONG;
            return EV_CLICK;
        endfunction

        // one accepted tick request: advance counters, track edges, maybe emit
        function void note_tick(bit level);
            click_event_t ev;
            ticks++;
            if (since_press != '1) since_press++;
            if (since_release != '1) since_release++;
            if (level && !held) begin
                held = 1'b1;
                since_press = '0;
                if (presses != 2'd3) presses++;
            end else if (!level && held) begin
                held = 1'b0;
                since_release = '0;
                if (since_press >= long_ticks) long_seen = 1'b1;
                if (presses == 2'd1) wait_armed = 1'b1;
            end
            if (!held && ((presses == 2'd1 && wait_armed && since_release > double_ticks) ||
                          presses > 2'd1)) begin
                ev.kind = classify();
                ev.tag = button_tag;
                expected_events.push_back(ev);
                wait_armed = 1'b0;
                presses = '0;
                long_seen = 1'b0;
            end
        endfunction

        task report(string msg);
            $display("ERROR at %0t: %s", $time, msg);
            errors++;
        endtask

        task check_event(logic [TAG_W-1:0] tag, logic [KIND_W-1:0] kind);
            click_event_t want;
            if (expected_events.size() == 0) begin
                report($sformatf("unexpected event kind %0d tag %0d", kind, tag));
            end else begin
                want = expected_events.pop_front();
                kind_count[int'(want.kind)]++;
                if (kind !== want.kind)
                    report($sformatf("event kind %0d, expected %s", kind, want.kind.name()));
                if (tag !== want.tag)
                    report($sformatf("button tag %0d, expected %0d", tag, want.tag));
            end
        endtask

        function int pending();
            return expected_events.size();
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic [S_TDATA_W-1:0]  i_s_tdata = '0;
    logic                  i_m_tready = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  o_s_tready;
    logic                  o_m_tvalid;
    logic [TAG_W-1:0]      o_m_tdata;
    logic [KIND_W-1:0]     o_m_tuser;
    logic                  o_cfg_ready;

    click_scoreboard tracker;
    int          burst_left = 0;
    int          long_holds_asked = 0;
    int          long_holds_granted = 0;
    int          hold_left = 0;
    int          mode_left = 0;
    sink_mode_t  sink_mode = SINK_READY;
    logic [7:0]  sink_pattern = 8'hA5;
    int unsigned cycle_count = 0;

    button_click_classifier_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),      // [0] level, [7:1] zero
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),      // [7:0] button_tag
        .o_m_tuser   (o_m_tuser),      // [1:0] event_kind
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // event sink: check accepted events, then pick the next ready value
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) tracker.check_event(o_m_tdata, o_m_tuser);
        if (long_holds_granted != long_holds_asked) begin
            hold_left = LONG_HOLD_CYCLES;
            long_holds_granted++;
        end
        if (mode_left == 0) begin
            sink_mode = sink_mode_t'($urandom_range(0, 3));
            mode_left = $urandom_range(32, 256);
            sink_pattern = 8'($urandom) | 8'h01;
        end else begin
            mode_left--;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_tready <= 1'b0;
        end else begin
            case (sink_mode)
                SINK_READY: i_m_tready <= 1'b1;
                SINK_MOSTLY: i_m_tready <= ($urandom_range(0, 3) != 0);
                SINK_SPARSE: i_m_tready <= ($urandom_range(0, 3) == 0);
                default: begin
                    i_m_tready <= sink_pattern[0];
                    sink_pattern = {sink_pattern[0], sink_pattern[7:1]};
                end
            endcase
        end
    end

    // watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("button_click_classifier_core_test failed");
        $finish;
    end

    // one tick request, with bursts and random gaps on the sender side
    task send_tick(bit level);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_s_tvalid <= 1'b1;
        i_s_tdata <= {{(S_TDATA_W-1){1'b0}}, level};
        do @(posedge i_clk); while (!o_s_tready);
        tracker.note_tick(level);
    endtask

    task send_pattern(string levels);
        for (int i = 0; i < levels.len(); i++) send_tick(levels[i] == "1");
    endtask

    task send_run(bit level, int count);
        repeat (count) send_tick(level);
    endtask

    // stop sending and wait until every predicted event has come out
    task settle();
        i_s_tvalid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task cfg_request(t_cfg_reg r, logic [CFG_DATA_W-1:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= r;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        tracker.write_reg(r, v);
    endtask

    task write_config(logic [TICKS_W-1:0] long_v, logic [TICKS_W-1:0] double_v,
                      logic [TAG_W-1:0] tag_v);
        cfg_request(CFG_LONG_TICKS, long_v);
        cfg_request(CFG_DOUBLE_TICKS, double_v);
        cfg_request(CFG_BUTTON_NUM, {{(CFG_DATA_W-TAG_W){1'b0}}, tag_v});
        i_cfg_valid <= 1'b0;
    endtask

    // mostly press/release gestures sized around the thresholds, some random noise
    task random_gestures(int n);
        int sent;
        int press_len;
        int gap_len;
        sent = 0;
        while (sent < n) begin
            if ($urandom_range(0, 9) < 8) begin
                press_len = $urandom_range(1, 2 * int'(tracker.long_ticks) + 1);
                if ($urandom_range(0, 1) == 1)
                    gap_len = $urandom_range(1, int'(tracker.double_ticks));
                else
                    gap_len = $urandom_range(int'(tracker.double_ticks) + 1,
                                             int'(tracker.double_ticks) + 4);
                send_run(1'b1, press_len);
                send_run(1'b0, gap_len);
                sent += press_len + gap_len;
            end else begin
                gap_len = $urandom_range(1, 6);
                repeat (gap_len) send_tick(1'($urandom_range(0, 1)));
                sent += gap_len;
            end
        end
    endtask

    initial begin
        tracker = new();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset defaults: button already down on the first tick, then a double click
        send_pattern("11010");
        settle();

        // short thresholds: click, long press, double click, click then long press
        write_config(16'd2, 16'd1, 8'h5A);
        send_pattern("1000");
        send_pattern("111000");
        send_pattern("1010");
        send_pattern("101110");
        settle();

        // maximum thresholds: nothing times out, the second release reports a double click
        write_config(16'hFFFF, 16'hFFFE, 8'hFF);
        send_run(1'b1, MAX_RUN);
        send_run(1'b0, MAX_RUN);
        send_run(1'b1, MAX_RUN / 2);
        send_run(1'b0, MAX_RUN / 2);
        settle();

        // minimum thresholds with a long sink stall so the output stage backs up
        write_config(16'd1, 16'd1, 8'h00);
        long_holds_asked++;
        random_gestures(GESTURE_TICKS);
        settle();

        repeat (3) begin
            write_config(TICKS_W'($urandom_range(1, 12)), TICKS_W'($urandom_range(1, 10)),
                         TAG_W'($urandom_range(0, 255)));
            random_gestures(GESTURE_TICKS);
            settle();
        end

        $display("ran %0d ticks, %0d events: %0d click, %0d double, %0d long, %0d click+long",
                 tracker.ticks, tracker.kind_count[0] + tracker.kind_count[1] +
                 tracker.kind_count[2] + tracker.kind_count[3], tracker.kind_count[0],
                 tracker.kind_count[1], tracker.kind_count[2], tracker.kind_count[3]);
        $display("thresholds from minimum to maximum, tags 0 to 255, %0d mismatches",
                 tracker.errors);
        if (tracker.errors == 0)
            $display("button_click_classifier_core_test passed");
        else
            $display("button_click_classifier_core_test failed");
        $finish;
    end

endmodule

// ----- button_click_classifier_core.f -----
+incdir+hdl
hdl/bcc_pkg.sv
hdl/bcc_update.sv
hdl/bcc_out_skid.sv
hdl/button_click_classifier_core.sv
dv/button_click_classifier_core_test.sv
